// ===== rtl/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcs_pkg: shared constants for the multichannel conv2d block
// Sample, product and result widths and the fixed frame limits.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  localparam int unsigned PAD_MAX     = 4;
  localparam int unsigned HEIGHT_MAX  = 256;
  localparam int unsigned NUM_SAMPLES = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PIX_W       = NUM_SAMPLES * SAMPLE_W;
  localparam int unsigned PROD_W      = 2 * SAMPLE_W;
  localparam int unsigned OUT_W       = 40;
  localparam int unsigned POS_W       = 9;

endpackage

`default_nettype wire

// ===== rtl/mcs_line_mem.sv =====
// ----------------------------------------------------------------------------
// mcs_line_mem: line store memory
// One write and one registered read port; zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_line_mem #(
  parameter int unsigned DEPTH = 264,
  parameter int unsigned WIDTH = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     busy_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] ra_i,
  output logic [WIDTH-1:0]         rd_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic             clr_busy_q;
  logic [AW-1:0]    clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem_q[ra_i];
    end
  end

  assign busy_o = clr_busy_q;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire

// ===== rtl/mcs_lane.sv =====
// ----------------------------------------------------------------------------
// mcs_lane: one channel of the window multiply-add
// Registered products, then a registered sum over the kernel taps.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_lane #(
  parameter int unsigned TAPS  = 9,
  parameter int unsigned SUM_W = 36
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0]   samp_i [TAPS],
  input  logic signed [mcs_pkg::SAMPLE_W-1:0]   wt_i   [TAPS],
  output logic signed [SUM_W-1:0]               sum_o
);

  import mcs_pkg::*;

  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_q[i] <= samp_i[i] * wt_i[i];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum_d = sum_d + SUM_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/multichannel_conv2d_stride_pad.sv =====
// ----------------------------------------------------------------------------
// multichannel_conv2d_stride_pad: streaming strided, padded 2-D convolution
// Loads kernel weights, then takes padded-frame pixels in raster order and
// emits one bias-added window sum per stride-aligned window.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//  in      | in_valid_i/in_stall_o  | req_type_i, weight_*, sample_0..3_i
//  out     | out_valid_o/out_stall_i| out_value_o, out_row_o, out_col_o, last_o
//
//  One request per cycle while in_stall_o is low.
//  Pipeline: position/divide, line store + window, products, lane sums,
//  channel merge into the output register.
//  After reset the line store is zeroed, one entry per cycle; in_stall_o stays
//  high over all LINE_LEN (MAX_WIDTH + 8) entries. Config writes always taken.
//  A held result freezes the whole pipeline and raises in_stall_o with it.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_conv2d_stride_pad #(
  parameter int unsigned KERNEL_W  = 3,
  parameter int unsigned KERNEL_H  = 3,
  parameter int unsigned MAX_DEPTH = 4,
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [3:0]                         cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [5:0]                         weight_index_i,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0] weight_value_i,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0] sample_0_i,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0] sample_1_i,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0] sample_2_i,
  input  logic signed [mcs_pkg::SAMPLE_W-1:0] sample_3_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mcs_pkg::OUT_W-1:0]   out_value_o,
  output logic [mcs_pkg::POS_W-1:0]          out_row_o,
  output logic [mcs_pkg::POS_W-1:0]          out_col_o,
  output logic                               last_o
);

  import mcs_pkg::*;

  // register map
  typedef enum logic [3:0] {
    CFG_IMG_WIDTH  = 4'd0,
    CFG_IMG_HEIGHT = 4'd1,
    CFG_STRIDE_H   = 4'd2,
    CFG_STRIDE_V   = 4'd3,
    CFG_PAD_H      = 4'd4,
    CFG_PAD_V      = 4'd5,
    CFG_BIAS       = 4'd6,
    CFG_CHANNELS   = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    REQ_WEIGHT = 1'b0,
    REQ_PIXEL  = 1'b1
  } req_e;

  localparam int unsigned LINE_LEN = MAX_WIDTH + 2 * PAD_MAX;
  localparam int unsigned CLW      = $clog2(LINE_LEN + 1);
  localparam int unsigned DW       = (CLW > POS_W) ? CLW : POS_W;
  localparam int unsigned K        = DW + 4;        // reciprocal precision
  localparam int unsigned RW       = K + 1;
  localparam int unsigned LAW      = $clog2(LINE_LEN);
  localparam int unsigned TAPS     = KERNEL_W * KERNEL_H;
  localparam int unsigned NL       = (MAX_DEPTH < NUM_SAMPLES) ? MAX_DEPTH : NUM_SAMPLES;
  localparam int unsigned WD_FULL  = MAX_DEPTH * TAPS;
  localparam int unsigned WS       = (WD_FULL < 64) ? WD_FULL : 64;
  localparam int unsigned WIW      = (WS > 1) ? $clog2(WS) : 1;
  localparam int unsigned SUM_W    = PROD_W + $clog2(TAPS);
  localparam int unsigned LROWS    = (KERNEL_H > 1) ? KERNEL_H - 1 : 1;
  localparam int unsigned LW       = LROWS * PIX_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [8:0]        img_width_q, img_height_q;
  logic [3:0]        stride_h_q, stride_v_q;
  logic [2:0]        pad_h_q, pad_v_q, chan_q;
  logic signed [31:0] bias_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= 9'd256;
      img_height_q <= 9'd256;
      stride_h_q   <= 4'd1;
      stride_v_q   <= 4'd1;
      pad_h_q      <= 3'd0;
      pad_v_q      <= 3'd0;
      bias_q       <= '0;
      chan_q       <= 3'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMG_WIDTH:  img_width_q  <= cfg_data_i[8:0];
        CFG_IMG_HEIGHT: img_height_q <= cfg_data_i[8:0];
        CFG_STRIDE_H:   stride_h_q   <= cfg_data_i[3:0];
        CFG_STRIDE_V:   stride_v_q   <= cfg_data_i[3:0];
        CFG_PAD_H:      pad_h_q      <= cfg_data_i[2:0];
        CFG_PAD_V:      pad_v_q      <= cfg_data_i[2:0];
        CFG_BIAS:       bias_q       <= signed'(cfg_data_i);
        CFG_CHANNELS:   chan_q       <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // effective (clamped) settings
  logic [DW-1:0] w_eff, h_eff, ph_eff, pv_eff, pw, pht;
  logic [3:0]    sh_eff, sv_eff;
  logic [2:0]    nch_eff;

  always_comb begin
    if (img_width_q == '0)                       w_eff = DW'(1);
    else if (DW'(img_width_q) > DW'(MAX_WIDTH))  w_eff = DW'(MAX_WIDTH);
    else                                         w_eff = DW'(img_width_q);
    if (img_height_q == '0)                      h_eff = DW'(1);
    else if (DW'(img_height_q) > DW'(HEIGHT_MAX)) h_eff = DW'(HEIGHT_MAX);
    else                                         h_eff = DW'(img_height_q);
    ph_eff  = (pad_h_q > 3'(PAD_MAX)) ? DW'(PAD_MAX) : DW'(pad_h_q);
    pv_eff  = (pad_v_q > 3'(PAD_MAX)) ? DW'(PAD_MAX) : DW'(pad_v_q);
    pw      = w_eff + (ph_eff << 1);
    pht     = h_eff + (pv_eff << 1);
    sh_eff  = (stride_h_q == '0) ? 4'd1 : stride_h_q;
    sv_eff  = (stride_v_q == '0) ? 4'd1 : stride_v_q;
    if (chan_q == '0)            nch_eff = 3'd1;
    else if (chan_q > 3'(NL))    nch_eff = 3'(NL);
    else                         nch_eff = chan_q;
  end

  // reciprocals ceil(2^K / s): exact quotient for every frame position
  logic [RW-1:0] recip_tbl [16];
  for (genvar gs = 0; gs < 16; gs++) begin : g_rcp
    localparam longint unsigned DEN = (gs == 0) ? 1 : gs;
    localparam logic [RW-1:0]   RCP = RW'(((64'd1 << K) + DEN - 1) / DEN);
    assign recip_tbl[gs] = RCP;
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a held result freezes every stage
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic clr_busy;
  logic accept;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv || clr_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // stage 0: frame position, padding, stride quotients
  // ---------------------------------------------------------------------------
  logic [DW-1:0] frame_col_q, frame_row_q;
  logic [DW-1:0] fc, fr, nc, nr, c0, r0, nw_num, nh_num;
  logic          in_frame, win_ok;
  logic [PIX_W-1:0] pix;
  logic [DW+RW-1:0] qx_full, qy_full, nw_full, nh_full;
  logic          is_pix;

  assign is_pix = (req_type_i == REQ_PIXEL);

  always_comb begin
    fc = frame_col_q;
    fr = frame_row_q;
    if (fc >= pw) begin
      fc = '0;
      fr = frame_row_q + DW'(1);
    end
    if (fr >= pht) begin
      fr = '0;
    end
    in_frame = (fc >= ph_eff) && (fc < ph_eff + w_eff) &&
               (fr >= pv_eff) && (fr < pv_eff + h_eff);
    pix = in_frame ? {sample_3_i, sample_2_i, sample_1_i, sample_0_i} : '0;
    nc = fc + DW'(1);
    nr = fr;
    if (nc >= pw) begin
      nc = '0;
      nr = fr + DW'(1);
      if (nr >= pht) begin
        nr = '0;
      end
    end
    win_ok = (fr >= DW'(KERNEL_H - 1)) && (fc >= DW'(KERNEL_W - 1));
    r0     = fr - DW'(KERNEL_H - 1);
    c0     = fc - DW'(KERNEL_W - 1);
    nw_num = pw - DW'(KERNEL_W);
    nh_num = pht - DW'(KERNEL_H);
    qx_full = (DW+RW)'(c0) * (DW+RW)'(recip_tbl[sh_eff]);
    qy_full = (DW+RW)'(r0) * (DW+RW)'(recip_tbl[sv_eff]);
    nw_full = (DW+RW)'(nw_num) * (DW+RW)'(recip_tbl[sh_eff]);
    nh_full = (DW+RW)'(nh_num) * (DW+RW)'(recip_tbl[sv_eff]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_col_q <= '0;
      frame_row_q <= '0;
    end else if (accept && is_pix) begin
      frame_col_q <= nc;
      frame_row_q <= nr;
    end
  end

  typedef struct packed {
    logic             pixel;
    logic [DW-1:0]    col;
    logic [PIX_W-1:0] pix;
    logic             win_ok;
    logic [DW-1:0]    c0;
    logic [DW-1:0]    r0;
    logic [DW-1:0]    qx;
    logic [DW-1:0]    qy;
    logic [DW-1:0]    nwq;
    logic [DW-1:0]    nhq;
    logic [3:0]       sh;
    logic [3:0]       sv;
    logic [5:0]       widx;
    logic [SAMPLE_W-1:0] wval;
  } s1_t;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic [5:0]       widx;
    logic [SAMPLE_W-1:0] wval;
    logic [POS_W-1:0] oy;
    logic [POS_W-1:0] ox;
    logic             last;
  } meta_t;

  logic  s1_v_q;
  s1_t   s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && accept) begin
      s1_q.pixel  <= is_pix;
      s1_q.col    <= fc;
      s1_q.pix    <= pix;
      s1_q.win_ok <= win_ok;
      s1_q.c0     <= c0;
      s1_q.r0     <= r0;
      s1_q.qx     <= qx_full[K +: DW];
      s1_q.qy     <= qy_full[K +: DW];
      s1_q.nwq    <= nw_full[K +: DW];
      s1_q.nhq    <= nh_full[K +: DW];
      s1_q.sh     <= sh_eff;
      s1_q.sv     <= sv_eff;
      s1_q.widx   <= weight_index_i;
      s1_q.wval   <= weight_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: line store column, window shift, stride check
  // ---------------------------------------------------------------------------
  logic [LW-1:0]        ln_rd, row_src, ln_wd;
  logic [LW+PIX_W-1:0]  ln_cat;
  logic                 ln_we;
  logic                 fwd_v_q;
  logic [DW-1:0]        fwd_col_q;
  logic [LW-1:0]        fwd_data_q;
  logic [PIX_W-1:0]     colv [KERNEL_H];
  logic [PIX_W-1:0]     win_q [KERNEL_H][KERNEL_W];

  if (KERNEL_H > 1) begin : g_line
    mcs_line_mem #(
      .DEPTH (LINE_LEN),
      .WIDTH (LW)
    ) u_line (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .busy_o (clr_busy),
      .we_i   (ln_we),
      .wa_i   (s1_q.col[LAW-1:0]),
      .wd_i   (ln_wd),
      .re_i   (adv && accept && is_pix),
      .ra_i   (fc[LAW-1:0]),
      .rd_o   (ln_rd)
    );
  end else begin : g_noline
    assign clr_busy = 1'b0;
    assign ln_rd    = '0;
  end

  // a write and a read of the same column at one edge (frame one pixel wide)
  assign row_src = (fwd_v_q && fwd_col_q == s1_q.col) ? fwd_data_q : ln_rd;
  assign ln_cat  = {s1_q.pix, row_src};
  assign ln_wd   = ln_cat[LW+PIX_W-1:PIX_W];
  assign ln_we   = adv && s1_v_q && s1_q.pixel;

  always_comb begin
    for (int ky = 0; ky < KERNEL_H - 1; ky++) begin
      colv[ky] = ln_cat[ky*PIX_W +: PIX_W];
    end
    colv[KERNEL_H-1] = s1_q.pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (adv) begin
      fwd_v_q <= s1_v_q && s1_q.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_col_q  <= s1_q.col;
      fwd_data_q <= ln_wd;
    end
    if (ln_we) begin
      for (int ky = 0; ky < KERNEL_H; ky++) begin
        for (int kx = 0; kx < KERNEL_W - 1; kx++) begin
          win_q[ky][kx] <= win_q[ky][kx+1];
        end
        win_q[ky][KERNEL_W-1] <= colv[ky];
      end
    end
  end

  logic  emit1, last1;
  meta_t s2_q, s3_q, s4_q;

  always_comb begin
    emit1 = s1_v_q && s1_q.pixel && s1_q.win_ok &&
            ((DW+4)'(s1_q.qx) * (DW+4)'(s1_q.sh) == (DW+4)'(s1_q.c0)) &&
            ((DW+4)'(s1_q.qy) * (DW+4)'(s1_q.sv) == (DW+4)'(s1_q.r0));
    last1 = (s1_q.qx == s1_q.nwq) && (s1_q.qy == s1_q.nhq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else if (adv) begin
      s2_q.load <= s1_v_q && !s1_q.pixel;
      s2_q.emit <= emit1;
      s2_q.widx <= s1_q.widx;
      s2_q.wval <= s1_q.wval;
      s2_q.oy   <= s1_q.qy[POS_W-1:0];
      s2_q.ox   <= s1_q.qx[POS_W-1:0];
      s2_q.last <= last1;
      s3_q      <= s2_q;
      s4_q      <= s3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: weight store (written in step with the product stage) and lanes
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] wt_q [WS];

  always_ff @(posedge clk_i) begin
    if (adv && s2_q.load && (7'(s2_q.widx) < 7'(WS))) begin
      wt_q[s2_q.widx[WIW-1:0]] <= signed'(s2_q.wval);
    end
  end

  logic signed [SUM_W-1:0] lane_sum [NL];

  for (genvar gc = 0; gc < NL; gc++) begin : g_lane
    logic signed [SAMPLE_W-1:0] l_samp [TAPS];
    logic signed [SAMPLE_W-1:0] l_wt   [TAPS];

    for (genvar gt = 0; gt < TAPS; gt++) begin : g_tap
      localparam int unsigned KY = gt / KERNEL_W;
      localparam int unsigned KX = gt % KERNEL_W;
      localparam int unsigned WI = gc * TAPS + gt;
      assign l_samp[gt] = signed'(win_q[KY][KX][gc*SAMPLE_W +: SAMPLE_W]);
      if (WI < WS) begin : g_w
        assign l_wt[gt] = wt_q[WI];
      end else begin : g_nw
        assign l_wt[gt] = '0;
      end
    end

    mcs_lane #(
      .TAPS  (TAPS),
      .SUM_W (SUM_W)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .samp_i (l_samp),
      .wt_i   (l_wt),
      .sum_o  (lane_sum[gc])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 4: merge the used channels, add bias, output register
  // ---------------------------------------------------------------------------
  logic signed [OUT_W-1:0] merge_d;
  logic signed [OUT_W-1:0] out_value_q;
  logic [POS_W-1:0]        out_row_q, out_col_q;
  logic                    last_q;

  always_comb begin
    merge_d = OUT_W'(bias_q);
    for (int l = 0; l < NL; l++) begin
      if (3'(l) < nch_eff) begin
        merge_d = merge_d + OUT_W'(lane_sum[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_q.emit) begin
      out_value_q <= merge_d;
      out_row_q   <= s4_q.oy;
      out_col_q   <= s4_q.ox;
      last_q      <= s4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("request taken during line store clear");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s4_q.emit) && $stable(s2_q.emit))
    else $error("pipeline moved while result held");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_col_q <= DW'(LINE_LEN))
    else $error("frame column beyond line store");

  a_load_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.load |-> !s2_q.emit)
    else $error("weight load produced a result");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_multichannel_conv2d_stride_pad.sv =====
// ----------------------------------------------------------------------------
// tb_multichannel_conv2d_stride_pad: self-checking bench for the conv2d block
// Loads kernels, streams padded frames under several layer settings with
// random idle and stall bursts, and checks every window sum against a
// cycle-free predictor of the convolution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichannel_conv2d_stride_pad;

  localparam int KW = 3;
  localparam int KH = 3;
  localparam int WDEPTH = 4 * KW * KH;
  localparam int LINE_LEN = 256 + 2 * mcs_pkg::PAD_MAX;
  localparam int LIMIT = 300000;
  localparam int QUIET_CYCLES = 12;

  // register indexes
  localparam logic [3:0] REG_WIDTH = 4'd0;
  localparam logic [3:0] REG_HEIGHT = 4'd1;
  localparam logic [3:0] REG_STRIDE_H = 4'd2;
  localparam logic [3:0] REG_STRIDE_V = 4'd3;
  localparam logic [3:0] REG_PAD_H = 4'd4;
  localparam logic [3:0] REG_PAD_V = 4'd5;
  localparam logic [3:0] REG_BIAS = 4'd6;
  localparam logic [3:0] REG_CHANNELS = 4'd7;
  localparam logic [3:0] REG_UNUSED = 4'd9;

  // request kinds in the pending queue
  localparam logic OP_REQ = 1'b0;
  localparam logic OP_CFG = 1'b1;
  // request types
  localparam logic RT_WEIGHT = 1'b0;
  localparam logic RT_PIXEL = 1'b1;

  typedef struct {
    logic        kind;
    logic        req_type;
    logic [5:0]  widx;
    logic [15:0] wval;
    logic [15:0] smp [4];
    logic [3:0]  cidx;
    logic [31:0] cdata;
  } op_t;

  typedef struct {
    logic [39:0] value;
    logic [8:0]  row;
    logic [8:0]  col;
    logic        last;
  } sum_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [5:0] weight_index_i = '0;
  logic signed [15:0] weight_value_i = '0;
  logic signed [15:0] sample_0_i = '0;
  logic signed [15:0] sample_1_i = '0;
  logic signed [15:0] sample_2_i = '0;
  logic signed [15:0] sample_3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [39:0] out_value_o;
  logic [8:0] out_row_o;
  logic [8:0] out_col_o;
  logic last_o;

  multichannel_conv2d_stride_pad uut (.*);

  // predictor state
  logic [31:0] layer_reg [8];
  logic [15:0] kernel_mem [WDEPTH];
  logic [63:0] line_mem [KH-1][LINE_LEN];
  logic [63:0] win [KH][KW];
  int unsigned pos_col, pos_row;

  op_t  pending [$];
  sum_t sums_due [$];
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  logic calm = 1'b0;     // last stretch: no idling on either side

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void write_layer_reg(logic [3:0] idx, logic [31:0] d);
    logic [31:0] mask [8] = '{32'h1FF, 32'h1FF, 32'hF, 32'hF, 32'h7, 32'h7,
                              32'hFFFF_FFFF, 32'h7};
    if (idx < 8) layer_reg[idx] = d & mask[idx];
  endfunction

  // One accepted request: load a weight, or update the frame model and queue a window sum if due.
  function automatic void conv_step(op_t r);
    int unsigned w, h, sh, sv, ph, pv, nch, pw, pht, col, row;
    int unsigned r0, c0, oy, ox, nh, nw;
    logic [63:0] pix, colv [KH];
    longint acc;
    logic in_frame;
    sum_t s;
    if (r.req_type == RT_WEIGHT) begin
      if (r.widx < WDEPTH) kernel_mem[r.widx] = r.wval;
      return;
    end
    w = clampu(layer_reg[REG_WIDTH], 1, 256);
    h = clampu(layer_reg[REG_HEIGHT], 1, 256);
    sh = layer_reg[REG_STRIDE_H] == 0 ? 1 : layer_reg[REG_STRIDE_H];
    sv = layer_reg[REG_STRIDE_V] == 0 ? 1 : layer_reg[REG_STRIDE_V];
    ph = clampu(layer_reg[REG_PAD_H], 0, 4);
    pv = clampu(layer_reg[REG_PAD_V], 0, 4);
    nch = clampu(layer_reg[REG_CHANNELS], 1, 4);
    pw = w + 2 * ph;
    pht = h + 2 * pv;
    if (pos_col >= pw) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= pht) pos_row = 0;
    col = pos_col;
    row = pos_row;
    in_frame = col >= ph && col < ph + w && row >= pv && row < pv + h;
    pix = in_frame ? {r.smp[3], r.smp[2], r.smp[1], r.smp[0]} : 64'd0;
    // window column: two buffered rows plus the new pixel
    colv[0] = line_mem[0][col];
    colv[1] = line_mem[1][col];
    colv[2] = pix;
    line_mem[0][col] = line_mem[1][col];
    line_mem[1][col] = pix;
    for (int ky = 0; ky < KH; ky++) begin
      win[ky][0] = win[ky][1];
      win[ky][1] = win[ky][2];
      win[ky][2] = colv[ky];
    end
    if (row + 1 >= KH && col + 1 >= KW) begin
      r0 = row + 1 - KH;
      c0 = col + 1 - KW;
      if (r0 % sv == 0 && c0 % sh == 0) begin
        oy = r0 / sv;
        ox = c0 / sh;
        nh = (pht - KH) / sv + 1;
        nw = (pw - KW) / sh + 1;
        acc = longint'($signed(layer_reg[REG_BIAS]));
        for (int c = 0; c < nch; c++)
          for (int ky = 0; ky < KH; ky++)
            for (int kx = 0; kx < KW; kx++)
              acc += longint'($signed(win[ky][kx][16*c +: 16])) *
                     longint'($signed(kernel_mem[(c * KH + ky) * KW + kx]));
        s.value = acc[39:0];
        s.row = oy[8:0];
        s.col = ox[8:0];
        s.last = (oy + 1 == nh && ox + 1 == nw);
        sums_due = {sums_due, s};
      end
    end
    pos_col = col + 1;
    if (pos_col >= pw) begin
      pos_col = 0;
      pos_row = row + 1;
      if (pos_row >= pht) pos_row = 0;
    end
  endfunction

  // --- stimulus builders ---
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_cfg(logic [3:0] idx, logic [31:0] d);
    op_t o;
    o.kind = OP_CFG;
    o.cidx = idx;
    o.cdata = d;
    pending = {pending, o};
  endfunction

  function automatic void add_weight(logic [5:0] idx, logic [15:0] v);
    op_t o;
    o.kind = OP_REQ;
    o.req_type = RT_WEIGHT;
    o.widx = idx;
    o.wval = v;
    for (int c = 0; c < 4; c++) o.smp[c] = 16'($urandom);
    pending = {pending, o};
  endfunction

  function automatic void add_pixels(int n);
    op_t o;
    for (int i = 0; i < n; i++) begin
      o.kind = OP_REQ;
      o.req_type = RT_PIXEL;
      o.widx = 6'($urandom);
      o.wval = 16'($urandom);
      for (int c = 0; c < 4; c++) o.smp[c] = pick_sample();
      pending = {pending, o};
    end
  endfunction

  // Writes all layer registers and streams whole padded frames.
  // Returns the number of pixels queued.
  function automatic int add_layer(int unsigned w, int unsigned h, int unsigned sh,
                                   int unsigned sv, int unsigned ph, int unsigned pv,
                                   logic [31:0] bias, int unsigned ch, int frames);
    int n;
    add_cfg(REG_WIDTH, w);
    add_cfg(REG_HEIGHT, h);
    add_cfg(REG_STRIDE_H, sh);
    add_cfg(REG_STRIDE_V, sv);
    add_cfg(REG_PAD_H, ph);
    add_cfg(REG_PAD_V, pv);
    add_cfg(REG_BIAS, bias);
    add_cfg(REG_CHANNELS, ch);
    n = frames * (clampu(w, 1, 256) + 2 * clampu(ph, 0, 4)) *
        (clampu(h, 1, 256) + 2 * clampu(pv, 0, 4));
    add_pixels(n);
    return n;
  endfunction

  initial begin
    int rnd_items;
    layer_reg = '{32'd256, 32'd256, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1};
    foreach (kernel_mem[i]) kernel_mem[i] = '0;
    foreach (line_mem[a, b]) line_mem[a][b] = '0;
    foreach (win[a, b]) win[a][b] = '0;
    pos_col = 0;
    pos_row = 0;

    // directed: full kernel with extreme weights, ignored out-of-range slots
    for (int i = 0; i < WDEPTH; i++)
      add_weight(6'(i), i % 4 == 0 ? 16'h8000 : (i % 4 == 1 ? 16'h7FFF : 16'($urandom)));
    add_weight(6'd36, 16'h1234);
    add_weight(6'd63, 16'h7FFF);
    add_cfg(REG_UNUSED, $urandom);
    void'(add_layer(4, 4, 1, 1, 0, 0, 32'h7FFF_FFFF, 4, 1));
    // zero width/stride/channels act as one, smallest useful frame
    void'(add_layer(0, 3, 0, 0, 1, 0, 32'h8000_0000, 0, 1));
    // stride of eight, pad above four, channel count above four
    void'(add_layer(3, 3, 8, 8, 7, 4, $urandom, 7, 1));
    // frame smaller than the kernel: nothing comes out
    void'(add_layer(1, 1, 1, 1, 0, 0, 32'd0, 1, 2));
    // wide and tall planes
    void'(add_layer(40, 1, 3, 1, 0, 1, $urandom, 2, 1));
    void'(add_layer(1, 20, 1, 5, 1, 0, $urandom, 3, 1));

    // random layers on small planes
    rnd_items = 0;
    while (rnd_items < 90) begin
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        add_weight(6'($urandom_range(0, 63)), 16'($urandom));
        rnd_items++;
      end
      rnd_items += add_layer($urandom_range(1, 6), $urandom_range(1, 6),
                             $urandom_range(0, 7) == 0 ? 8 : $urandom_range(1, 3),
                             $urandom_range(0, 7) == 0 ? 8 : $urandom_range(1, 3),
                             $urandom_range(0, 2), $urandom_range(0, 2), $urandom,
                             $urandom_range(1, 4), $urandom_range(1, 2));
      // occasional broken frame: the next layer starts mid-frame
      if ($urandom_range(0, 9) == 0) add_pixels($urandom_range(1, 4));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --- driver: requests and register writes ---
  int gap = 0;
  int quiet = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv, ncv;
    op_t o;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      nv = in_valid_i;
      ncv = cfg_valid_i;
      if (in_valid_i && !in_stall_o) begin
        o.req_type = req_type_i;
        o.widx = weight_index_i;
        o.wval = weight_value_i;
        o.smp = '{sample_0_i, sample_1_i, sample_2_i, sample_3_i};
        conv_step(o);
        nv = 1'b0;
        quiet = 0;
        if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
      end else if (sums_due.size() != 0) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_layer_reg(cfg_index_i, cfg_data_i);
        ncv = 1'b0;
      end
      if (!nv && !ncv) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() != 0) begin
          o = pending[0];
          if (o.kind == OP_CFG) begin
            // block must be drained before touching the layer registers
            if (quiet >= QUIET_CYCLES) begin
              void'(pending.pop_front());
              ncv = 1'b1;
              cfg_index_i <= o.cidx;
              cfg_data_i <= o.cdata;
            end
          end else begin
            void'(pending.pop_front());
            nv = 1'b1;
            req_type_i <= o.req_type;
            weight_index_i <= o.widx;
            weight_value_i <= o.wval;
            sample_0_i <= o.smp[0];
            sample_1_i <= o.smp[1];
            sample_2_i <= o.smp[2];
            sample_3_i <= o.smp[3];
          end
        end
      end
      in_valid_i <= nv;
      cfg_valid_i <= ncv;
      calm <= pending.size() < 80;
    end
  end

  // --- monitor: result checks and stall bursts ---
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    sum_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (sums_due.size() == 0) begin
          report("unexpected result", out_value_o, '0);
        end else begin
          e = sums_due.pop_front();
          if (out_value_o !== e.value) report("value", out_value_o, e.value);
          if (out_row_o !== e.row) report("row", out_row_o, e.row);
          if (out_col_o !== e.col) report("col", out_col_o, e.col);
          if (last_o !== e.last) report("last", last_o, e.last);
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 19);
      out_stall_i <= stall_left != 0;
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("tb_multichannel_conv2d_stride_pad: errors");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || cfg_valid_i || sums_due.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sums_due.size() != 0) report("missing results", sums_due.size(), '0);
    if (err_cnt == 0) begin
      $display("tb_multichannel_conv2d_stride_pad: clean");
    end else begin
      $display("tb_multichannel_conv2d_stride_pad: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mcs_pkg.sv
rtl/mcs_line_mem.sv
rtl/mcs_lane.sv
rtl/multichannel_conv2d_stride_pad.sv
tb/tb_multichannel_conv2d_stride_pad.sv
